FILE: hdl/ntcg_pkg.sv
// Shared types, constants and the NTC curve table of the charge guard.
package ntcg_pkg;

    // Field and register widths
    localparam int MV_W   = 12;
    localparam int UV_W   = 22;
    localparam int TDC_W  = 11;
    localparam int HYS_W  = 8;
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 2;

    // Curve table shape
    localparam int TABLE_ENTRIES = 18;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int QW            = TDC_W;
    localparam int NUM_W         = TDC_W + UV_W;
    localparam int CNT_W         = $clog2(QW);

    localparam logic [UV_W-1:0] UV_PER_MV = UV_W'(1000);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TEMP_MIN = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_TEMP_MAX = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_HYST     = CIDX_W'(2);

    // Register reset values
    localparam logic signed [TDC_W-1:0] TEMP_MIN_RST = TDC_W'(0);
    localparam logic signed [TDC_W-1:0] TEMP_MAX_RST = TDC_W'(600);
    localparam logic [HYS_W-1:0]        HYST_RST     = HYS_W'(30);

    // Result range of the curve
    localparam logic signed [TDC_W-1:0] TDC_LOWEST  = -TDC_W'(200);
    localparam logic signed [TDC_W-1:0] TDC_HIGHEST = TDC_W'(650);

    // Controller commands to the datapath
    typedef struct packed {
        logic load;  // capture the transaction, start at entry one
        logic top;   // clamp to the first entry
        logic seek;  // advance to the next entry
        logic mul;   // form the interpolation product
        logic div;   // one quotient bit
        logic fin;   // write the result register and the guard flag
    } t_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic ok;        // captured reading is usable
        logic at_top;    // voltage at or above the first entry
        logic hit;       // voltage at or above the current entry
        logic last;      // current entry is the final one
        logic div_last;  // final quotient bit this cycle
        logic out_free;  // result register can take a new result
    } t_sts;

    // Curve voltage in microvolts, falling with entry number
    function automatic logic [UV_W-1:0] ntc_uv(input logic [IDX_W-1:0] idx);
        logic [UV_W-1:0] v;
        case (idx)
            IDX_W'(0):  v = UV_W'(1095000);
            IDX_W'(1):  v = UV_W'(986000);
            IDX_W'(2):  v = UV_W'(878000);
            IDX_W'(3):  v = UV_W'(775000);
            IDX_W'(4):  v = UV_W'(678000);
            IDX_W'(5):  v = UV_W'(590000);
            IDX_W'(6):  v = UV_W'(510000);
            IDX_W'(7):  v = UV_W'(440000);
            IDX_W'(8):  v = UV_W'(378000);
            IDX_W'(9):  v = UV_W'(324000);
            IDX_W'(10): v = UV_W'(278000);
            IDX_W'(11): v = UV_W'(238000);
            IDX_W'(12): v = UV_W'(204000);
            IDX_W'(13): v = UV_W'(175000);
            IDX_W'(14): v = UV_W'(150000);
            IDX_W'(15): v = UV_W'(129000);
            IDX_W'(16): v = UV_W'(111000);
            IDX_W'(17): v = UV_W'(96000);
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Curve temperature in tenths of a degree
    function automatic logic signed [TDC_W-1:0] ntc_tdc(input logic [IDX_W-1:0] idx);
        logic signed [TDC_W-1:0] t;
        case (idx)
            IDX_W'(0):  t = -TDC_W'(200);
            IDX_W'(1):  t = -TDC_W'(150);
            IDX_W'(2):  t = -TDC_W'(100);
            IDX_W'(3):  t = -TDC_W'(50);
            IDX_W'(4):  t = TDC_W'(0);
            IDX_W'(5):  t = TDC_W'(50);
            IDX_W'(6):  t = TDC_W'(100);
            IDX_W'(7):  t = TDC_W'(150);
            IDX_W'(8):  t = TDC_W'(200);
            IDX_W'(9):  t = TDC_W'(250);
            IDX_W'(10): t = TDC_W'(300);
            IDX_W'(11): t = TDC_W'(350);
            IDX_W'(12): t = TDC_W'(400);
            IDX_W'(13): t = TDC_W'(450);
            IDX_W'(14): t = TDC_W'(500);
            IDX_W'(15): t = TDC_W'(550);
            IDX_W'(16): t = TDC_W'(600);
            IDX_W'(17): t = TDC_W'(650);
            default:    t = '0;
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/ntc_temperature_charge_guard.sv
// Top level of the battery NTC temperature charge guard.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_ntc_millivolts, i_reading_ok
//  result    out        o_valid / i_ready    o_temperature_dc, o_temperature_valid,
//                                            o_charging_blocked, o_charge_toggle
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
//  One transaction at a time: accept, the top clamp check, a walk over the
//  curve entries (up to 17), a multiply, 11 quotient bits from the restoring
//  divider and the result write.
//  The curve walk and the bit-serial divider set the time per item.
//  Reset is synchronous, active low; it restores the limits and clears the guard.
//  A stalled result waits in the output register; the next transaction is
//  accepted as soon as that result has been written there.
module ntc_temperature_charge_guard (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ntcg_pkg::MV_W-1:0]            i_ntc_millivolts,
    input  logic                                 i_reading_ok,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ntcg_pkg::TDC_W-1:0]    o_temperature_dc,
    output logic                                 o_temperature_valid,
    output logic                                 o_charging_blocked,
    output logic                                 o_charge_toggle,
    input  logic                                 i_cfg_we,
    input  logic [ntcg_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [ntcg_pkg::CFG_W-1:0]           i_cfg_data
);

    ntcg_pkg::t_cmd cmd;
    ntcg_pkg::t_sts sts;

    // Sequencer
    ntcg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // Arithmetic and result register
    ntcg_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_ntc_millivolts    (i_ntc_millivolts),
        .i_reading_ok        (i_reading_ok),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_temperature_dc    (o_temperature_dc),
        .o_temperature_valid (o_temperature_valid),
        .o_charging_blocked  (o_charging_blocked),
        .o_charge_toggle     (o_charge_toggle)
    );

endmodule

FILE: hdl/ntcg_ctrl.sv
// Sequencing state machine of the charge guard: table walk, divide, result.
module ntcg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ntcg_pkg::t_sts i_sts,
    output logic          o_ready,
    output ntcg_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TOP  = 6'b000010,
        S_SEEK = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    // Decode commands and the next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TOP;
                end
            end
            S_TOP: begin
                if (!i_sts.ok) begin
                    n_state = S_FIN;
                end else if (i_sts.at_top) begin
                    o_cmd.top = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (i_sts.hit) begin
                    n_state = S_MUL;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.seek = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/ntcg_dp.sv
// Datapath of the charge guard: scaling, curve walk, serial divide, decision.
module ntcg_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ntcg_pkg::t_cmd                       i_cmd,
    output ntcg_pkg::t_sts                       o_sts,
    input  logic [ntcg_pkg::MV_W-1:0]            i_ntc_millivolts,
    input  logic                                 i_reading_ok,
    input  logic                                 i_cfg_we,
    input  logic [ntcg_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [ntcg_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic signed [ntcg_pkg::TDC_W-1:0]    o_temperature_dc,
    output logic                                 o_temperature_valid,
    output logic                                 o_charging_blocked,
    output logic                                 o_charge_toggle
);

    localparam int UV_W  = ntcg_pkg::UV_W;
    localparam int TDC_W = ntcg_pkg::TDC_W;
    localparam int QW    = ntcg_pkg::QW;
    localparam int IDX_W = ntcg_pkg::IDX_W;
    localparam int CNT_W = ntcg_pkg::CNT_W;
    localparam int NUM_W = ntcg_pkg::NUM_W;

    // Configuration
    logic signed [TDC_W-1:0]        r_temp_min, r_temp_max;
    logic [ntcg_pkg::HYS_W-1:0]     r_hyst;

    // Working registers
    logic [UV_W-1:0]                r_uv;
    logic                           r_ok;
    logic [IDX_W-1:0]               r_idx;
    logic [UV_W-1:0]                r_rem;
    logic [QW-1:0]                  r_num;
    logic [QW-1:0]                  r_q;
    logic                           r_neg;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_blocked;

    // Curve lookups at the current entry
    logic [UV_W-1:0]                lo_uv, hi_uv, span, diff;
    logic signed [TDC_W-1:0]        tdc_cur, tdc_prv;
    logic signed [TDC_W:0]          step;
    logic [TDC_W-1:0]               mag;
    logic [NUM_W-1:0]               prod;
    logic [UV_W:0]                  trial;
    logic signed [TDC_W:0]          temp_w, lim_lo, lim_hi, hyst_s;
    logic                           block;

    assign lo_uv   = ntcg_pkg::ntc_uv(r_idx);
    assign hi_uv   = ntcg_pkg::ntc_uv(r_idx - IDX_W'(1));
    assign span    = hi_uv - lo_uv;
    assign diff    = r_uv - lo_uv;
    assign tdc_cur = ntcg_pkg::ntc_tdc(r_idx);
    assign tdc_prv = ntcg_pkg::ntc_tdc(r_idx - IDX_W'(1));
    assign step    = (TDC_W+1)'(tdc_cur) - (TDC_W+1)'(tdc_prv);
    assign mag     = step[TDC_W] ? TDC_W'(-step) : TDC_W'(step);
    assign prod    = NUM_W'(mag) * NUM_W'(diff);
    assign trial   = {r_rem, r_num[QW-1]} - {1'b0, span};

    // Status to the controller
    assign o_sts.ok       = r_ok;
    assign o_sts.at_top   = (r_uv >= ntcg_pkg::ntc_uv('0));
    assign o_sts.hit      = (r_uv >= lo_uv);
    assign o_sts.last     = (r_idx == IDX_W'(ntcg_pkg::TABLE_ENTRIES - 1));
    assign o_sts.div_last = (r_cnt == CNT_W'(QW - 1));
    assign o_sts.out_free = !o_valid || i_ready;

    // Temperature from the entry and the quotient, then the guard decision
    assign temp_w = r_neg ? ((TDC_W+1)'(tdc_cur) + (TDC_W+1)'(r_q))
                          : ((TDC_W+1)'(tdc_cur) - (TDC_W+1)'(r_q));
    assign hyst_s = r_blocked ? (TDC_W+1)'({1'b0, r_hyst}) : '0;
    assign lim_lo = (TDC_W+1)'(r_temp_min) + hyst_s;
    assign lim_hi = (TDC_W+1)'(r_temp_max) - hyst_s;
    assign block  = (temp_w < lim_lo) || (temp_w > lim_hi);

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_min <= ntcg_pkg::TEMP_MIN_RST;
            r_temp_max <= ntcg_pkg::TEMP_MAX_RST;
            r_hyst     <= ntcg_pkg::HYST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ntcg_pkg::CFG_TEMP_MIN: r_temp_min <= i_cfg_data;
                ntcg_pkg::CFG_TEMP_MAX: r_temp_max <= i_cfg_data;
                ntcg_pkg::CFG_HYST:     r_hyst     <= i_cfg_data[ntcg_pkg::HYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture, walk the curve, form the product and shift out quotient bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_uv  <= UV_W'(i_ntc_millivolts) * ntcg_pkg::UV_PER_MV;
            r_ok  <= i_reading_ok;
            r_idx <= IDX_W'(1);
            r_q   <= '0;
            r_neg <= 1'b0;
        end
        if (i_cmd.top) begin
            r_idx <= '0;
        end
        if (i_cmd.seek) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.mul) begin
            r_rem <= prod[NUM_W-1:QW];
            r_num <= prod[QW-1:0];
            r_neg <= step[TDC_W];
            r_cnt <= '0;
        end
        if (i_cmd.div) begin
            if (!trial[UV_W]) begin
                r_rem <= trial[UV_W-1:0];
            end else begin
                r_rem <= {r_rem[UV_W-2:0], r_num[QW-1]};
            end
            r_num <= {r_num[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], !trial[UV_W]};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Hold the result register and the guard flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid   <= 1'b0;
            r_blocked <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                o_valid <= 1'b1;
                if (r_ok) begin
                    r_blocked <= block;
                end
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_temperature_dc    <= r_ok ? temp_w[TDC_W-1:0] : '0;
            o_temperature_valid <= r_ok;
            o_charging_blocked  <= r_ok ? block : r_blocked;
            o_charge_toggle     <= r_ok && (block != r_blocked);
        end
    end

`ifndef SYNTHESIS
    // The divide remainder stays below the segment span
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> (r_rem < span))
        else $error("divide remainder not below span");

    // A delivered valid temperature lies on the curve
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_temperature_valid) |->
            (o_temperature_dc >= ntcg_pkg::TDC_LOWEST &&
             o_temperature_dc <= ntcg_pkg::TDC_HIGHEST))
        else $error("temperature outside curve range");

    // A toggle only follows a usable reading
    a_toggle_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_charge_toggle) |-> o_temperature_valid)
        else $error("toggle on invalid reading");

    // The guard flag follows the delivered decision
    a_flag_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (r_blocked == o_charging_blocked))
        else $error("guard flag differs from decision");
`endif

endmodule
